[design/pcst_pkg.sv]
// ----------------------------------------------------------------------------
// pcst_pkg
// Shared types and constants of the probability-chain segment tree: payload
// structs, status codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package pcst_pkg;

    localparam int TREE_LEAVES = 1024;
    localparam int LEAF_W      = $clog2(TREE_LEAVES);
    localparam int NODE_W      = LEAF_W + 1;
    localparam int IDX_W       = NODE_W + 1;
    localparam int FRAC_W      = 32;
    localparam int Q_W         = FRAC_W + 1;
    localparam int CNT_W       = 11;
    localparam int POS_W       = 10;
    localparam int DIV_W       = $clog2(FRAC_W);

    localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};

    localparam logic [CNT_W-1:0] LEAF_COUNT_RESET = CNT_W'(TREE_LEAVES);

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] range_start;
        logic [CNT_W-1:0] range_end;
        logic [Q_W-1:0]   success_prob;
    } pcst_in_t;

    typedef struct packed {
        logic [Q_W-1:0] pass_prob;
        logic [Q_W-1:0] back_prob;
        logic [1:0]     status;
    } pcst_out_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_START, U_LEAF, U_RD0, U_RD1, U_CAP,
        C_MUL1, C_DEN, C_DIV, C_MUL2, C_MUL3, C_MUL4, C_FIN, C_POST,
        Q_TEST, Q_RDL, Q_CAPL, Q_RTEST, Q_RDR, Q_CAPR, Q_SHIFT, Q_FINAL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CTX_UPD, CTX_QL, CTX_QR, CTX_QF
    } ctx_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_CAPTURE, OP_START, OP_LEAF_WR,
        OP_RD_CH0, OP_RD_CH1, OP_CAP_UPD,
        OP_MUL_DEN, OP_DEN, OP_DIV, OP_MUL_PASS, OP_MUL_BK1, OP_MUL_BK2, OP_FIN,
        OP_PAR_WR, OP_RD_L, OP_CAP_QL, OP_RD_R, OP_CAP_QR, OP_LOAD_FINAL,
        OP_POST_QL, OP_POST_QR, OP_SHIFT, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } pcst_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_query;
        logic den_trivial;
        logic div_last;
        logic n_is_root;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic out_busy;
    } pcst_sts_t;

endpackage

[design/pcst_ctrl.sv]
// ----------------------------------------------------------------------------
// pcst_ctrl
// Controller of the segment tree: sequences the clearing pass, leaf updates,
// range queries and the steps of each merge through datapath commands.
// ----------------------------------------------------------------------------
module pcst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pcst_pkg::pcst_sts_t sts,
    output pcst_pkg::pcst_cmd_t cmd
);

    pcst_pkg::state_t state_reg;
    pcst_pkg::state_t state_next;
    pcst_pkg::ctx_t   ctx_reg;
    pcst_pkg::ctx_t   ctx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcst_pkg::S_CLEAR;
            ctx_reg   <= pcst_pkg::CTX_UPD;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        unique case (state_reg)
            pcst_pkg::S_CLEAR:
                if (sts.clr_last) state_next = pcst_pkg::S_IDLE;
            pcst_pkg::S_IDLE:
                if (req_valid) state_next = pcst_pkg::S_START;
            pcst_pkg::S_START:
                if (sts.bad) state_next = pcst_pkg::S_DONE;
                else if (sts.is_query) state_next = pcst_pkg::Q_TEST;
                else state_next = pcst_pkg::U_LEAF;
            pcst_pkg::U_LEAF:
                state_next = pcst_pkg::U_RD0;
            pcst_pkg::U_RD0:
                state_next = pcst_pkg::U_RD1;
            pcst_pkg::U_RD1:
                state_next = pcst_pkg::U_CAP;
            pcst_pkg::U_CAP:
            begin
                state_next = pcst_pkg::C_MUL1;
                ctx_next   = pcst_pkg::CTX_UPD;
            end
            pcst_pkg::C_MUL1:
                state_next = pcst_pkg::C_DEN;
            pcst_pkg::C_DEN:
                state_next = sts.den_trivial ? pcst_pkg::C_MUL2 : pcst_pkg::C_DIV;
            pcst_pkg::C_DIV:
                if (sts.div_last) state_next = pcst_pkg::C_MUL2;
            pcst_pkg::C_MUL2:
                state_next = pcst_pkg::C_MUL3;
            pcst_pkg::C_MUL3:
                state_next = pcst_pkg::C_MUL4;
            pcst_pkg::C_MUL4:
                state_next = pcst_pkg::C_FIN;
            pcst_pkg::C_FIN:
                state_next = pcst_pkg::C_POST;
            pcst_pkg::C_POST:
                unique case (ctx_reg)
                    pcst_pkg::CTX_UPD:
                        state_next = sts.n_is_root ? pcst_pkg::S_DONE : pcst_pkg::U_RD0;
                    pcst_pkg::CTX_QL: state_next = pcst_pkg::Q_RTEST;
                    pcst_pkg::CTX_QR: state_next = pcst_pkg::Q_SHIFT;
                    default:          state_next = pcst_pkg::S_DONE;
                endcase
            pcst_pkg::Q_TEST:
                if (sts.l_lt_r && sts.l_odd) state_next = pcst_pkg::Q_RDL;
                else if (sts.l_lt_r) state_next = pcst_pkg::Q_RTEST;
                else state_next = pcst_pkg::Q_FINAL;
            pcst_pkg::Q_RDL:
                state_next = pcst_pkg::Q_CAPL;
            pcst_pkg::Q_CAPL:
            begin
                state_next = pcst_pkg::C_MUL1;
                ctx_next   = pcst_pkg::CTX_QL;
            end
            pcst_pkg::Q_RTEST:
                state_next = sts.r_odd ? pcst_pkg::Q_RDR : pcst_pkg::Q_SHIFT;
            pcst_pkg::Q_RDR:
                state_next = pcst_pkg::Q_CAPR;
            pcst_pkg::Q_CAPR:
            begin
                state_next = pcst_pkg::C_MUL1;
                ctx_next   = pcst_pkg::CTX_QR;
            end
            pcst_pkg::Q_SHIFT:
                state_next = pcst_pkg::Q_TEST;
            pcst_pkg::Q_FINAL:
            begin
                state_next = pcst_pkg::C_MUL1;
                ctx_next   = pcst_pkg::CTX_QF;
            end
            pcst_pkg::S_DONE:
                if (!sts.out_busy) state_next = pcst_pkg::S_IDLE;
            default:
                state_next = pcst_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = pcst_pkg::OP_NONE;
        req_ready = 1'b0;
        unique case (state_reg)
            pcst_pkg::S_CLEAR: cmd.op = pcst_pkg::OP_CLEAR;
            pcst_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid) cmd.op = pcst_pkg::OP_CAPTURE;
            end
            pcst_pkg::S_START: cmd.op = pcst_pkg::OP_START;
            pcst_pkg::U_LEAF:  cmd.op = pcst_pkg::OP_LEAF_WR;
            pcst_pkg::U_RD0:   cmd.op = pcst_pkg::OP_RD_CH0;
            pcst_pkg::U_RD1:   cmd.op = pcst_pkg::OP_RD_CH1;
            pcst_pkg::U_CAP:   cmd.op = pcst_pkg::OP_CAP_UPD;
            pcst_pkg::C_MUL1:  cmd.op = pcst_pkg::OP_MUL_DEN;
            pcst_pkg::C_DEN:   cmd.op = pcst_pkg::OP_DEN;
            pcst_pkg::C_DIV:   cmd.op = pcst_pkg::OP_DIV;
            pcst_pkg::C_MUL2:  cmd.op = pcst_pkg::OP_MUL_PASS;
            pcst_pkg::C_MUL3:  cmd.op = pcst_pkg::OP_MUL_BK1;
            pcst_pkg::C_MUL4:  cmd.op = pcst_pkg::OP_MUL_BK2;
            pcst_pkg::C_FIN:   cmd.op = pcst_pkg::OP_FIN;
            pcst_pkg::C_POST:
                unique case (ctx_reg)
                    pcst_pkg::CTX_UPD: cmd.op = pcst_pkg::OP_PAR_WR;
                    pcst_pkg::CTX_QL:  cmd.op = pcst_pkg::OP_POST_QL;
                    pcst_pkg::CTX_QR:  cmd.op = pcst_pkg::OP_POST_QR;
                    default:           cmd.op = pcst_pkg::OP_NONE;
                endcase
            pcst_pkg::Q_TEST:  cmd.op = pcst_pkg::OP_NONE;
            pcst_pkg::Q_RDL:   cmd.op = pcst_pkg::OP_RD_L;
            pcst_pkg::Q_CAPL:  cmd.op = pcst_pkg::OP_CAP_QL;
            pcst_pkg::Q_RTEST: cmd.op = pcst_pkg::OP_NONE;
            pcst_pkg::Q_RDR:   cmd.op = pcst_pkg::OP_RD_R;
            pcst_pkg::Q_CAPR:  cmd.op = pcst_pkg::OP_CAP_QR;
            pcst_pkg::Q_SHIFT: cmd.op = pcst_pkg::OP_SHIFT;
            pcst_pkg::Q_FINAL: cmd.op = pcst_pkg::OP_LOAD_FINAL;
            pcst_pkg::S_DONE:
                if (!sts.out_busy) cmd.op = pcst_pkg::OP_OUT;
            default:           cmd.op = pcst_pkg::OP_NONE;
        endcase
    end

endmodule

[design/pcst_dp.sv]
// ----------------------------------------------------------------------------
// pcst_dp
// Datapath of the segment tree: node memory, request and result registers,
// tree indexes, and the merge unit with a shared multiplier and a radix-2
// restoring divider.
// ----------------------------------------------------------------------------
module pcst_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcst_pkg::pcst_cmd_t                 cmd,
    output pcst_pkg::pcst_sts_t                 sts,
    input  pcst_pkg::pcst_in_t                  req,
    input  logic                                cfg_valid,
    input  logic [pcst_pkg::CNT_W-1:0]          cfg_data,
    output pcst_pkg::pcst_out_t                 rsp,
    output logic                                rsp_valid,
    input  logic                                rsp_ready
);

    localparam int NODES = 2 * pcst_pkg::TREE_LEAVES;
    localparam int NW    = pcst_pkg::NODE_W;
    localparam int IW    = pcst_pkg::IDX_W;
    localparam int QW    = pcst_pkg::Q_W;
    localparam int FW    = pcst_pkg::FRAC_W;

    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] x, input logic [QW-1:0] y);
        logic [2*FW-1:0] p;
        begin
            p = x[FW-1:0] * y[FW-1:0];
            if (x >= pcst_pkg::Q_ONE) qmul = y;
            else if (y >= pcst_pkg::Q_ONE) qmul = x;
            else qmul = {1'b0, p[2*FW-1:FW]};
        end
    endfunction

    logic [2*QW-1:0] mem [0:NODES-1];
    logic [2*QW-1:0] rdata_reg;
    logic            we;
    logic [NW-1:0]   waddr;
    logic [2*QW-1:0] wdata;
    logic            re;
    logic [NW-1:0]   raddr;

    pcst_pkg::pcst_in_t          item_reg;
    logic [pcst_pkg::CNT_W-1:0]  leaf_count_reg;
    logic [NW-1:0]               clr_cnt_reg;
    logic [NW-1:0]               n_reg;
    logic [IW-1:0]               l_reg;
    logic [IW-1:0]               r_reg;
    logic [QW-1:0]               accl_p_reg, accl_b_reg, accr_p_reg, accr_b_reg;
    logic [QW-1:0]               a_reg, d_reg, b_reg, e_reg;
    logic [QW-1:0]               t_reg, den_reg, rem_reg, q_reg;
    logic [QW-1:0]               pres_reg, bres_reg;
    logic [pcst_pkg::DIV_W-1:0]  cnt_reg;
    logic                        zflag_reg;
    logic                        bad_reg;
    pcst_pkg::pcst_out_t         out_reg;
    logic                        out_valid_reg;

    logic [pcst_pkg::CNT_W-1:0]  lim;
    logic                        bad_c;
    logic [QW-1:0]               psat;
    logic [NW-1:0]               leaf_node;
    logic [IW-1:0]               r_m1;
    logic [QW-1:0]               mul_x, mul_y, prod;
    logic [QW-1:0]               den_c;
    logic [QW:0]                 rem2, rem_diff;
    logic                        rem_ge;
    logic [QW:0]                 bk_sum;
    pcst_pkg::pcst_out_t         out_c;

    assign lim = (leaf_count_reg > pcst_pkg::LEAF_COUNT_RESET) ? pcst_pkg::LEAF_COUNT_RESET
                                                               : leaf_count_reg;
    always_comb
    begin
        if (item_reg.kind == pcst_pkg::KIND_QUERY)
            bad_c = ({1'b0, item_reg.range_start} > item_reg.range_end)
                 || (item_reg.range_end > lim);
        else
            bad_c = ({1'b0, item_reg.position} >= lim);
    end

    assign psat      = (item_reg.success_prob > pcst_pkg::Q_ONE) ? pcst_pkg::Q_ONE
                                                                : item_reg.success_prob;
    assign leaf_node = {1'b1, item_reg.position[pcst_pkg::LEAF_W-1:0]};
    assign r_m1      = r_reg - IW'(1);
    assign den_c     = pcst_pkg::Q_ONE - t_reg;
    assign rem2      = {rem_reg, 1'b0};
    assign rem_diff  = rem2 - {1'b0, den_reg};
    assign rem_ge    = (rem2 >= {1'b0, den_reg});
    assign bk_sum    = {1'b0, e_reg} + {1'b0, t_reg};

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.op)
            pcst_pkg::OP_MUL_DEN:
            begin
                mul_x = pcst_pkg::Q_ONE - b_reg;
                mul_y = d_reg;
            end
            pcst_pkg::OP_MUL_PASS:
            begin
                mul_x = a_reg;
                mul_y = q_reg;
            end
            pcst_pkg::OP_MUL_BK1:
            begin
                mul_x = pcst_pkg::Q_ONE - e_reg;
                mul_y = d_reg;
            end
            pcst_pkg::OP_MUL_BK2:
            begin
                mul_x = t_reg;
                mul_y = q_reg;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod = qmul(mul_x, mul_y);

    always_comb
    begin
        we    = 1'b0;
        waddr = clr_cnt_reg;
        wdata = {pcst_pkg::Q_ONE, {QW{1'b0}}};
        re    = 1'b0;
        raddr = l_reg[NW-1:0];
        unique case (cmd.op)
            pcst_pkg::OP_CLEAR:
                we = 1'b1;
            pcst_pkg::OP_LEAF_WR:
            begin
                we    = 1'b1;
                waddr = leaf_node;
                wdata = {psat, psat};
            end
            pcst_pkg::OP_PAR_WR:
            begin
                we    = 1'b1;
                waddr = n_reg;
                wdata = {pres_reg, bres_reg};
            end
            pcst_pkg::OP_RD_CH0:
            begin
                re    = 1'b1;
                raddr = {n_reg[NW-2:0], 1'b0};
            end
            pcst_pkg::OP_RD_CH1:
            begin
                re    = 1'b1;
                raddr = {n_reg[NW-2:0], 1'b1};
            end
            pcst_pkg::OP_RD_L:
                re = 1'b1;
            pcst_pkg::OP_RD_R:
            begin
                re    = 1'b1;
                raddr = r_m1[NW-1:0];
            end
            default:
                we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        out_c.pass_prob = '0;
        out_c.back_prob = '0;
        out_c.status    = zflag_reg ? pcst_pkg::ST_ZDEN : pcst_pkg::ST_OK;
        if (bad_reg)
            out_c.status = pcst_pkg::ST_BAD;
        else if (item_reg.kind == pcst_pkg::KIND_QUERY)
        begin
            out_c.pass_prob = pres_reg;
            out_c.back_prob = bres_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= pcst_pkg::LEAF_COUNT_RESET;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid) leaf_count_reg <= cfg_data;
            if (cmd.op == pcst_pkg::OP_CLEAR) clr_cnt_reg <= clr_cnt_reg + NW'(1);
            if (cmd.op == pcst_pkg::OP_OUT) out_valid_reg <= 1'b1;
            else if (rsp_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            pcst_pkg::OP_CAPTURE: item_reg <= req;
            pcst_pkg::OP_START:
            begin
                bad_reg    <= bad_c;
                zflag_reg  <= 1'b0;
                l_reg      <= IW'(pcst_pkg::TREE_LEAVES) + IW'(item_reg.range_start);
                r_reg      <= IW'(pcst_pkg::TREE_LEAVES) + IW'(item_reg.range_end);
                accl_p_reg <= pcst_pkg::Q_ONE;
                accl_b_reg <= '0;
                accr_p_reg <= pcst_pkg::Q_ONE;
                accr_b_reg <= '0;
            end
            pcst_pkg::OP_LEAF_WR: n_reg <= leaf_node >> 1;
            pcst_pkg::OP_RD_CH1:
            begin
                a_reg <= rdata_reg[2*QW-1:QW];
                d_reg <= rdata_reg[QW-1:0];
            end
            pcst_pkg::OP_CAP_UPD:
            begin
                b_reg <= rdata_reg[2*QW-1:QW];
                e_reg <= rdata_reg[QW-1:0];
            end
            pcst_pkg::OP_CAP_QL:
            begin
                a_reg <= accl_p_reg;
                d_reg <= accl_b_reg;
                b_reg <= rdata_reg[2*QW-1:QW];
                e_reg <= rdata_reg[QW-1:0];
            end
            pcst_pkg::OP_CAP_QR:
            begin
                a_reg <= rdata_reg[2*QW-1:QW];
                d_reg <= rdata_reg[QW-1:0];
                b_reg <= accr_p_reg;
                e_reg <= accr_b_reg;
            end
            pcst_pkg::OP_LOAD_FINAL:
            begin
                a_reg <= accl_p_reg;
                d_reg <= accl_b_reg;
                b_reg <= accr_p_reg;
                e_reg <= accr_b_reg;
            end
            pcst_pkg::OP_MUL_DEN: t_reg <= prod;
            pcst_pkg::OP_DEN:
            begin
                den_reg <= den_c;
                rem_reg <= b_reg;
                cnt_reg <= '0;
                if (den_c == '0)
                begin
                    q_reg     <= '0;
                    zflag_reg <= 1'b1;
                end
                else if (b_reg >= den_c)
                    q_reg <= pcst_pkg::Q_ONE;
                else
                    q_reg <= '0;
            end
            pcst_pkg::OP_DIV:
            begin
                rem_reg <= rem_ge ? rem_diff[QW-1:0] : rem2[QW-1:0];
                q_reg   <= {q_reg[QW-2:0], rem_ge};
                cnt_reg <= cnt_reg + pcst_pkg::DIV_W'(1);
            end
            pcst_pkg::OP_MUL_PASS: pres_reg <= prod;
            pcst_pkg::OP_MUL_BK1:  t_reg <= prod;
            pcst_pkg::OP_MUL_BK2:  t_reg <= prod;
            pcst_pkg::OP_FIN:
                bres_reg <= (bk_sum > {1'b0, pcst_pkg::Q_ONE}) ? pcst_pkg::Q_ONE : bk_sum[QW-1:0];
            pcst_pkg::OP_PAR_WR: n_reg <= n_reg >> 1;
            pcst_pkg::OP_POST_QL:
            begin
                accl_p_reg <= pres_reg;
                accl_b_reg <= bres_reg;
                l_reg      <= l_reg + IW'(1);
            end
            pcst_pkg::OP_POST_QR:
            begin
                accr_p_reg <= pres_reg;
                accr_b_reg <= bres_reg;
            end
            pcst_pkg::OP_RD_R: r_reg <= r_m1;
            pcst_pkg::OP_SHIFT:
            begin
                l_reg <= l_reg >> 1;
                r_reg <= r_reg >> 1;
            end
            pcst_pkg::OP_OUT: out_reg <= out_c;
            default: ;
        endcase
    end

    assign sts.clr_last    = &clr_cnt_reg;
    assign sts.bad         = bad_c;
    assign sts.is_query    = (item_reg.kind == pcst_pkg::KIND_QUERY);
    assign sts.den_trivial = (den_c == '0) || (b_reg >= den_c);
    assign sts.div_last    = &cnt_reg;
    assign sts.n_is_root   = (n_reg == NW'(1));
    assign sts.l_lt_r      = (l_reg < r_reg);
    assign sts.l_odd       = l_reg[0];
    assign sts.r_odd       = r_reg[0];
    assign sts.out_busy    = out_valid_reg && !rsp_ready;

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule

[design/prob_chain_segment_tree.sv]
// ----------------------------------------------------------------------------
// prob_chain_segment_tree
// Segment tree of Q1.32 probability pairs with point update and ordered
// range merge.
// ----------------------------------------------------------------------------
// After reset the block sets every node to the neutral pair, and takes no
// request until then; the leaf count register can be written at any time
// the block is idle. Each request then runs alone. A merge runs through the
// 32-step serial divider, which it skips when the quotient is trivial, and
// four passes through the one shared multiplier. An update writes the leaf,
// then for each tree level reads both children, runs one merge and writes
// the parent. A query merges each boundary node into a left or a right
// running result, then merges the two in one final merge; a rejected
// request goes straight to its result.
module prob_chain_segment_tree (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  pcst_pkg::pcst_in_t         req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output pcst_pkg::pcst_out_t        rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pcst_pkg::CNT_W-1:0] cfg_data
);

    pcst_pkg::pcst_cmd_t cmd;
    pcst_pkg::pcst_sts_t sts;

    assign cfg_ready = 1'b1;

    pcst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pcst_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

`ifndef SYNTHESIS
    a_req_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (cmd.op == pcst_pkg::OP_START))
        else $error("Accepted request did not start processing.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.status == pcst_pkg::ST_OK) || (rsp.status == pcst_pkg::ST_BAD)
                    || (rsp.status == pcst_pkg::ST_ZDEN)))
        else $error("Result carries an undefined status.");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == pcst_pkg::ST_BAD))
            |-> ((rsp.pass_prob == '0) && (rsp.back_prob == '0)))
        else $error("Rejected request returned nonzero probabilities.");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == pcst_pkg::OP_DIV) && sts.div_last) |=> (cmd.op == pcst_pkg::OP_MUL_PASS))
        else $error("Divider did not hand over to the pass multiply.");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Probability-chain segment tree testbench
// Drives point updates and range queries through the request channel, keeps
// its own tree of Q1.32 pass/back pairs to work out each response, and checks
// every response field by field while both channels stall at random and the
// leaf count register is moved between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam longint unsigned ONE = 64'h1_0000_0000;
    localparam int MAX_CYCLES = 4000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    pcst_pkg::pcst_in_t req;
    logic rsp_valid;
    logic rsp_ready;
    pcst_pkg::pcst_out_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [pcst_pkg::CNT_W-1:0] cfg_data;

    pcst_pkg::pcst_in_t pending_requests[$];
    pcst_pkg::pcst_out_t expected_responses[$];
    longint unsigned tree_pass[2*pcst_pkg::TREE_LEAVES];
    longint unsigned tree_back[2*pcst_pkg::TREE_LEAVES];
    longint unsigned leaf_limit_reg;
    bit zero_den_hit;
    int mismatches;
    int cycles;
    bit req_taken;

    prob_chain_segment_tree DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    function automatic longint unsigned fx_mul(longint unsigned x, longint unsigned y);
        if (x >= ONE)
            return y;
        if (y >= ONE)
            return x;
        return (x * y) >> 32;
    endfunction

    function automatic void chain_merge(input longint unsigned lp, input longint unsigned lb,
                                        input longint unsigned rp, input longint unsigned rb,
                                        output longint unsigned op, output longint unsigned ob);
        longint unsigned den;
        longint unsigned q;
        longint unsigned bk;
        den = ONE - fx_mul(ONE - rp, lb);
        if (den == 0)
        begin
            q = 0;
            zero_den_hit = 1;
        end
        else if (rp >= den)
            q = ONE;
        else
            q = (rp << 32) / den;
        op = fx_mul(lp, q);
        bk = rb + fx_mul(fx_mul(ONE - rb, lb), q);
        ob = (bk > ONE) ? ONE : bk;
    endfunction

    function automatic void span_merge(input int lo, input int hi, input int n, input int a,
                                       input int b, output longint unsigned op,
                                       output longint unsigned ob);
        longint unsigned lp, lb, rp, rb;
        int c;
        if (hi <= a || lo >= b)
        begin
            op = ONE;
            ob = 0;
        end
        else if (lo <= a && b <= hi)
        begin
            op = tree_pass[n];
            ob = tree_back[n];
        end
        else
        begin
            c = (a + b) / 2;
            span_merge(lo, hi, 2 * n, a, c, lp, lb);
            span_merge(lo, hi, 2 * n + 1, c, b, rp, rb);
            chain_merge(lp, lb, rp, rb, op, ob);
        end
    endfunction

    function automatic pcst_pkg::pcst_out_t predict_response(pcst_pkg::pcst_in_t r);
        pcst_pkg::pcst_out_t o;
        longint unsigned lim;
        longint unsigned p, b;
        longint unsigned prob;
        int n;
        lim = (leaf_limit_reg > pcst_pkg::TREE_LEAVES) ? pcst_pkg::TREE_LEAVES
                                                       : leaf_limit_reg;
        zero_den_hit = 0;
        o = '0;
        o.status = pcst_pkg::ST_OK;
        if (r.kind == pcst_pkg::KIND_UPDATE)
        begin
            if (r.position >= lim)
            begin
                o.status = pcst_pkg::ST_BAD;
                return o;
            end
            prob = r.success_prob;
            if (prob > ONE)
                prob = ONE;
            n = pcst_pkg::TREE_LEAVES + r.position;
            tree_pass[n] = prob;
            tree_back[n] = prob;
            for (n = n >> 1; n > 0; n = n >> 1)
            begin
                chain_merge(tree_pass[2*n], tree_back[2*n], tree_pass[2*n+1],
                            tree_back[2*n+1], p, b);
                tree_pass[n] = p;
                tree_back[n] = b;
            end
        end
        else
        begin
            if (r.range_start > r.range_end || r.range_end > lim)
            begin
                o.status = pcst_pkg::ST_BAD;
                return o;
            end
            span_merge(r.range_start, r.range_end, 1, 0, pcst_pkg::TREE_LEAVES, p, b);
            o.pass_prob = p[pcst_pkg::Q_W-1:0];
            o.back_prob = b[pcst_pkg::Q_W-1:0];
        end
        if (zero_den_hit)
            o.status = pcst_pkg::ST_ZDEN;
        return o;
    endfunction

    function automatic pcst_pkg::pcst_in_t make_request(bit kind, int pos, int rs, int re,
                                                        longint unsigned prob);
        pcst_pkg::pcst_in_t r;
        r.kind = kind;
        r.position = pos[pcst_pkg::POS_W-1:0];
        r.range_start = rs[pcst_pkg::POS_W-1:0];
        r.range_end = re[pcst_pkg::CNT_W-1:0];
        r.success_prob = prob[pcst_pkg::Q_W-1:0];
        return r;
    endfunction

    function automatic longint unsigned random_prob();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return ONE;
            2: return {31'd0, 1'b1, 32'($urandom)};
            3: return $urandom_range(0, 255);
            4: return ONE - $urandom_range(1, 255);
            default: return {32'd0, 32'($urandom)};
        endcase
    endfunction

    function automatic pcst_pkg::pcst_in_t random_request(int lc);
        int lim;
        int re;
        int rs;
        lim = (lc > pcst_pkg::TREE_LEAVES) ? pcst_pkg::TREE_LEAVES : lc;
        if ($urandom_range(0, 1) == 0)
        begin
            if (lim > 0 && $urandom_range(0, 9) != 0)
                return make_request(pcst_pkg::KIND_UPDATE, $urandom_range(0, lim - 1),
                                    $urandom_range(0, 1023), $urandom_range(0, 2047),
                                    random_prob());
            return make_request(pcst_pkg::KIND_UPDATE, $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 2047),
                                random_prob());
        end
        if ($urandom_range(0, 9) != 0)
        begin
            re = $urandom_range(0, lim);
            rs = $urandom_range(0, (re > 1023) ? 1023 : re);
            if ($urandom_range(0, 9) == 0)
                rs = (re > 1023) ? 1023 : re;
        end
        else
        begin
            re = $urandom_range(0, 2047);
            rs = $urandom_range(0, 1023);
        end
        return make_request(pcst_pkg::KIND_QUERY, $urandom_range(0, 1023), rs, re,
                            {31'($urandom), 2'($urandom)});
    endfunction

    function automatic bit idle_now();
        if (cycles > 150000 && cycles < 300000)
            return 0;
        return $urandom_range(0, 99) < 33;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        req_taken <= req_valid && req_ready;
        if (req_valid && req_ready)
            expected_responses.push_back(predict_response(req));
        if (rsp_valid && rsp_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected response: pass=%h back=%h status=%0d",
                             rsp.pass_prob, rsp.back_prob, rsp.status);
            end
            else
            begin
                pcst_pkg::pcst_out_t e;
                e = expected_responses.pop_front();
                if (rsp.pass_prob !== e.pass_prob || rsp.back_prob !== e.back_prob ||
                    rsp.status !== e.status)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"Response mismatch: expected pass=%h back=%h status=%0d,",
                                  " got pass=%h back=%h status=%0d"},
                                 e.pass_prob, e.back_prob, e.status,
                                 rsp.pass_prob, rsp.back_prob, rsp.status);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_ready <= !idle_now();
        if (rst_n && (!req_valid || req_taken))
        begin
            if (pending_requests.size() > 0 && !idle_now())
            begin
                req <= pending_requests.pop_front();
                req_valid <= 1;
            end
            else
                req_valid <= 0;
        end
    end

    task automatic write_leaf_count(int value);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= value[pcst_pkg::CNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        leaf_limit_reg = value;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
            @(posedge clk);
    endtask

    int phase_limits[7] = '{1024, 16, 1, 0, 2047, 700, 1024};
    int phase_sizes[7] = '{150, 100, 60, 40, 150, 150, 100};

    initial
    begin
        int i;
        int k;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        rsp_ready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        req_taken = 0;
        for (i = 0; i < 2 * pcst_pkg::TREE_LEAVES; i++)
        begin
            tree_pass[i] = ONE;
            tree_back[i] = 0;
        end
        leaf_limit_reg = pcst_pkg::TREE_LEAVES;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_leaf_count(pcst_pkg::TREE_LEAVES);
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 0, 1024, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 5, 5, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 0, 0, 0, ONE));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 1, 0, 0, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 0, 2, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 1023, 0, 0,
                                                64'h1_FFFF_FFFF));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 512, 1023, 2047,
                                                64'h8000_0000));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 511, 0, 0,
                                                64'hFFFF_FFFF));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 1023, 1023, 1024, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 0, 1024, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 3, 700, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 10, 9, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 0, 1025, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 1023, 2047,
                                                64'h1_FFFF_FFFF));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 1, 0, 0, 1));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 0, 3, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 510, 514, 0));
        wait_drained();
        write_leaf_count(8);
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 8, 0, 0, 12345));
        pending_requests.push_back(make_request(pcst_pkg::KIND_UPDATE, 7, 0, 0, 12345));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 0, 9, 0));
        pending_requests.push_back(make_request(pcst_pkg::KIND_QUERY, 0, 2, 8, 0));
        wait_drained();

        for (k = 0; k < 7; k++)
        begin
            write_leaf_count(phase_limits[k]);
            for (i = 0; i < phase_sizes[k]; i++)
                pending_requests.push_back(random_request(phase_limits[k]));
            wait_drained();
        end
        repeat (50) @(posedge clk);

        if (mismatches == 0 && expected_responses.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
